FILE: src/rne_pkg.sv
// Shared types, character codes and numeral helper functions for the
// Roman numeral encoder. No dependencies.
`timescale 1ns / 1ps

package rne_pkg;

    // ASCII codes of the numeral letters and the run terminator
    localparam logic [6:0] CH_I  = 7'h49;
    localparam logic [6:0] CH_V  = 7'h56;
    localparam logic [6:0] CH_X  = 7'h58;
    localparam logic [6:0] CH_L  = 7'h4C;
    localparam logic [6:0] CH_C  = 7'h43;
    localparam logic [6:0] CH_D  = 7'h44;
    localparam logic [6:0] CH_M  = 7'h4D;
    localparam logic [6:0] CH_NL = 7'h0A;

    // Digit positions, most significant first
    localparam logic [1:0] POS_THOUS = 2'd0;
    localparam logic [1:0] POS_HUND  = 2'd1;
    localparam logic [1:0] POS_TENS  = 2'd2;
    localparam logic [1:0] POS_ONES  = 2'd3;

    // Which of the one/five/ten letters a numeral character uses
    typedef enum logic [1:0] {
        SEL_ONE  = 2'd0,
        SEL_FIVE = 2'd1,
        SEL_TEN  = 2'd2
    } sel_t;

    // Decimal digits of one value, handed from the front to the back
    typedef struct packed {
        logic [1:0] thous;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } cmd_t;

    // Status of the command queue
    typedef struct packed {
        logic full;
        logic avail;
    } q_status_t;

    // Number of numeral characters one decimal digit produces
    function automatic logic [2:0] digit_len(logic [3:0] d);
        logic [2:0] n;
        unique case (d)
            4'd0:    n = 3'd0;
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Letter kind for character idx of digit d (subtractive forms for 4 and 9)
    function automatic sel_t digit_sel(logic [3:0] d, logic [1:0] idx);
        sel_t s;
        if (d == 4'd9)
            s = (idx == 2'd0) ? SEL_ONE : SEL_TEN;
        else if (d == 4'd4)
            s = (idx == 2'd0) ? SEL_ONE : SEL_FIVE;
        else if (d >= 4'd5)
            s = (idx == 2'd0) ? SEL_FIVE : SEL_ONE;
        else
            s = SEL_ONE;
        return s;
    endfunction

    // ASCII letter for a digit position and letter kind
    function automatic logic [6:0] letter(logic [1:0] pos, sel_t s);
        logic [6:0] c;
        unique case (pos)
            POS_THOUS: c = CH_M;
            POS_HUND:  c = (s == SEL_ONE) ? CH_C : ((s == SEL_FIVE) ? CH_D : CH_M);
            POS_TENS:  c = (s == SEL_ONE) ? CH_X : ((s == SEL_FIVE) ? CH_L : CH_C);
            default:   c = (s == SEL_ONE) ? CH_I : ((s == SEL_FIVE) ? CH_V : CH_X);
        endcase
        return c;
    endfunction

endpackage

FILE: src/rne_if.sv
// Valid/ready channel interfaces for the value input and the character output.
// Depends on nothing.
`timescale 1ns / 1ps

interface rne_num_if;
    logic        valid;
    logic        ready;
    logic [11:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface rne_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

FILE: src/rne_front.sv
// Front end: accepts a value, saturates it and splits it into decimal digits,
// one digit per cycle. Depends on rne_pkg and rne_if.
`timescale 1ns / 1ps

module rne_front #(
    parameter int MAX_VALUE = 3999
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rne_num_if.sink              number,
    input  rne_pkg::q_status_t   q_status,
    output logic                 push,
    output rne_pkg::cmd_t        push_data
);

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_DIGIT = 3'b010,
        F_PUSH  = 3'b100
    } fstate_t;

    localparam logic [11:0] SAT_VALUE = 12'(MAX_VALUE);

    fstate_t        state_reg, state_next;
    logic [1:0]     step_reg, step_next;
    logic [11:0]    rem_reg, rem_next;
    rne_pkg::cmd_t  cmd_reg, cmd_next;

    logic [13:0]    thr [10];
    logic [3:0]     digit;
    logic [13:0]    sub;
    logic [11:0]    sat_value;

    // Thresholds k*weight for the digit being extracted
    always_comb
    begin
        thr[0] = 14'd0;
        for (int k = 1; k < 10; k++)
        begin
            case (step_reg)
                2'd0:    thr[k] = 14'(k * 1000);
                2'd1:    thr[k] = 14'(k * 100);
                default: thr[k] = 14'(k * 10);
            endcase
        end
    end

    // Count thresholds passed to get the digit, then take its multiple off
    always_comb
    begin
        digit = 4'd0;
        for (int k = 1; k < 10; k++)
            digit = digit + {3'd0, ({2'b00, rem_reg} >= thr[k])};
        sub      = thr[digit];
        rem_next = rem_reg - sub[11:0];
    end

    assign sat_value = (number.value > SAT_VALUE) ? SAT_VALUE : number.value;

    // Sequence: accept, three digit steps, push into the queue
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd_next   = cmd_reg;
        push       = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (number.valid)
                begin
                    step_next  = 2'd0;
                    state_next = F_DIGIT;
                end
            end
            F_DIGIT:
            begin
                case (step_reg)
                    2'd0:    cmd_next.thous = digit[1:0];
                    2'd1:    cmd_next.hund  = digit;
                    default: cmd_next.tens  = digit;
                endcase
                if (step_reg == 2'd2)
                begin
                    cmd_next.ones = rem_next[3:0];
                    state_next    = F_PUSH;
                end
                else
                begin
                    step_next = step_reg + 2'd1;
                end
            end
            F_PUSH:
            begin
                if (!q_status.full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    assign number.ready = (state_reg == F_IDLE);
    assign push_data    = cmd_reg;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Hold payload: remainder and digits
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (state_reg == F_IDLE)
            rem_reg <= sat_value;
        else if (state_reg == F_DIGIT)
            rem_reg <= rem_next;
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_DIGIT) |-> (step_reg != 2'd3))
        else $error("front digit step out of range");

    a_push_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!q_status.full && state_reg == F_PUSH))
        else $error("front pushed into a full queue");

endmodule

FILE: src/rne_queue.sv
// Two-entry command queue between the front end and the character back end.
// Depends on rne_pkg.
`timescale 1ns / 1ps

module rne_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rne_pkg::cmd_t        push_data,
    input  logic                 pop,
    output rne_pkg::cmd_t        pop_data,
    output rne_pkg::q_status_t   status
);

    localparam int DEPTH = 2;

    rne_pkg::cmd_t  entry_reg [DEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_push, do_pop;

    assign status.full  = (count_reg == 2'(DEPTH));
    assign status.avail = (count_reg != 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.avail;
    assign pop_data     = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH))
        else $error("queue occupancy above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> status.avail)
        else $error("queue popped while empty");

endmodule

FILE: src/rne_back.sv
// Back end: walks the digits of one command and emits numeral characters,
// one per cycle while the output is ready, closed by a newline. Depends on rne_pkg and rne_if.
`timescale 1ns / 1ps

module rne_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rne_pkg::cmd_t        q_data,
    input  rne_pkg::q_status_t   q_status,
    output logic                 pop,
    rne_char_if.source           numeral
);

    typedef enum logic [2:0] {
        B_IDLE    = 3'b001,
        B_LETTER  = 3'b010,
        B_NEWLINE = 3'b100
    } bstate_t;

    localparam logic [2:0] POS_NONE = 3'd4;

    bstate_t        state_reg, state_next;
    logic [1:0]     pos_reg, pos_next;
    logic [1:0]     idx_reg, idx_next;
    rne_pkg::cmd_t  cmd_reg;
    logic           ovalid_reg, ovalid_next;
    logic [6:0]     char_reg, char_next;
    logic           last_reg, last_next;

    logic           slot_free;
    logic [3:0]     cur_dig;
    logic [2:0]     cur_len;
    logic [6:0]     cur_char;
    logic [2:0]     first_load;
    logic [2:0]     next_after;

    // First digit position at or after start that yields characters
    function automatic logic [2:0] first_nonempty(rne_pkg::cmd_t c, logic [2:0] start);
        logic [3:0] d [4];
        logic [2:0] res;
        d[0] = {2'b00, c.thous};
        d[1] = c.hund;
        d[2] = c.tens;
        d[3] = c.ones;
        res  = POS_NONE;
        for (int p = 3; p >= 0; p--)
        begin
            if ((3'(p) >= start) && (rne_pkg::digit_len(d[p]) != 3'd0))
                res = 3'(p);
        end
        return res;
    endfunction

    // Decode the current character
    always_comb
    begin
        case (pos_reg)
            rne_pkg::POS_THOUS: cur_dig = {2'b00, cmd_reg.thous};
            rne_pkg::POS_HUND:  cur_dig = cmd_reg.hund;
            rne_pkg::POS_TENS:  cur_dig = cmd_reg.tens;
            default:            cur_dig = cmd_reg.ones;
        endcase
        cur_len    = rne_pkg::digit_len(cur_dig);
        cur_char   = rne_pkg::letter(pos_reg, rne_pkg::digit_sel(cur_dig, idx_reg));
        first_load = first_nonempty(q_data, 3'd0);
        next_after = first_nonempty(cmd_reg, {1'b0, pos_reg} + 3'd1);
    end

    assign slot_free = !ovalid_reg || numeral.ready;
    assign pop       = (state_reg == B_IDLE) && q_status.avail;

    // Sequence: load a command, emit its letters, then the newline
    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        ovalid_next = slot_free ? 1'b0 : ovalid_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_status.avail)
                begin
                    idx_next = 2'd0;
                    if (first_load == POS_NONE)
                    begin
                        state_next = B_NEWLINE;
                    end
                    else
                    begin
                        pos_next   = first_load[1:0];
                        state_next = B_LETTER;
                    end
                end
            end
            B_LETTER:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    char_next   = cur_char;
                    last_next   = 1'b0;
                    if (({1'b0, idx_reg} + 3'd1) == cur_len)
                    begin
                        idx_next = 2'd0;
                        if (next_after == POS_NONE)
                            state_next = B_NEWLINE;
                        else
                            pos_next = next_after[1:0];
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            B_NEWLINE:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    char_next   = rne_pkg::CH_NL;
                    last_next   = 1'b1;
                    state_next  = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    assign numeral.valid     = ovalid_reg;
    assign numeral.char_code = char_reg;
    assign numeral.last      = last_reg;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            pos_reg    <= 2'd0;
            idx_reg    <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Hold payload: loaded command and output character
    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= q_data;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    a_last_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && last_reg) |-> (char_reg == rne_pkg::CH_NL))
        else $error("last flag on a character other than newline");

    a_index_in_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_LETTER) |-> (({1'b0, idx_reg} + 3'd1) <= cur_len))
        else $error("character index past the end of its digit");

endmodule

FILE: src/roman_numeral_encoder.sv
// The front end takes a value through accept, three digit steps and push, and
// takes a new value only after it has pushed the last one; a full queue holds
// the front at push. The back end emits a run of 1..16 characters, including
// the newline, one character per cycle while the output is ready.
// Reset (rst_n low, asynchronous): front idle, queue empty, no output valid.
`timescale 1ns / 1ps

module roman_numeral_encoder #(
    parameter int MAX_VALUE = 3999
) (
    input  logic        clk,
    input  logic        rst_n,
    rne_num_if.sink     number,
    rne_char_if.source  numeral
);

    logic                push;
    logic                pop;
    rne_pkg::cmd_t       push_data;
    rne_pkg::cmd_t       pop_data;
    rne_pkg::q_status_t  q_status;

    // Accept values and split them into digits
    rne_front #(
        .MAX_VALUE (MAX_VALUE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .number    (number),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // Decouple digit extraction from character output
    rne_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // Emit the numeral characters
    rne_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (pop_data),
        .q_status (q_status),
        .pop      (pop),
        .numeral  (numeral)
    );

endmodule
